FILE: rtl/core/debounced_dual_servo_ramp_defines.svh
// assertion macros for the debounced dual servo ramp
`ifndef DEBOUNCED_DUAL_SERVO_RAMP_DEFINES_SVH
`define DEBOUNCED_DUAL_SERVO_RAMP_DEFINES_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define DDSR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition that must never be true out of reset
`define DDSR_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define DDSR_ASSERT(lbl, prop, msg)
`define DDSR_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

FILE: rtl/core/ddsr_pkg.sv
// types and constants for the debounced dual servo ramp
package ddsr_pkg;

    localparam int POS_W     = 8;
    localparam int POS_CNT   = 1 << POS_W;
    localparam int TICK_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;
    localparam int SERVOS    = 2;

    localparam logic [TICK_W-1:0] DEBOUNCE_RESET = 16'd80;
    localparam logic [TICK_W-1:0] STEP_RESET     = 16'd20;
    localparam logic [POS_W-1:0]  ON_A_RESET     = 8'd29;
    localparam logic [POS_W-1:0]  ON_B_RESET     = 8'd32;
    localparam logic [POS_W-1:0]  OFF_A_RESET    = 8'd0;
    localparam logic [POS_W-1:0]  OFF_B_RESET    = 8'd0;
    localparam logic [TICK_W-1:0] TICK_MAX       = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_TICKS = 3'd0,
        CFG_STEP_TICKS     = 3'd1,
        CFG_ON_POSITION_A  = 3'd2,
        CFG_ON_POSITION_B  = 3'd3,
        CFG_OFF_POSITION_A = 3'd4,
        CFG_OFF_POSITION_B = 3'd5
    } cfg_reg_t;

    // result item, position_a in the lowest bits
    typedef struct packed {
        logic             demand_stable;
        logic             on_state;
        logic             moving;
        logic [POS_W-1:0] position_b;
        logic [POS_W-1:0] position_a;
    } out_item_t;

    localparam int OUT_W   = $bits(out_item_t);
    localparam int M_DATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int S_DATA_W = 8;

endpackage

FILE: rtl/core/debounced_dual_servo_ramp.sv
// debounced on/off demand driving two servos along a linear ramp
`include "debounced_dual_servo_ramp_defines.svh"

// One tick item can be accepted in every clock cycle. Its result is registered at the
// accepting edge into the result register, which the master side offers, or into a skid
// register behind it while that holds an item not taken; input keeps flowing while one
// result waits and stalls only while both hold an item. The step index is kept pre-scaled
// by a reciprocal of the step count, so each ramp position is one small multiply and a
// shift with no divider; end positions written during a ramp act on the next tick.
module debounced_dual_servo_ramp
    import ddsr_pkg::*;
#(
    parameter int MOVE_STEPS = 250
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // demand_raw
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // position_a, position_b, moving, on_state,
                                            // demand_stable
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int IDX_W = $clog2(MOVE_STEPS + 1);
    localparam logic [IDX_W-1:0] STEPS_I = IDX_W'(MOVE_STEPS);

    // reciprocal of the step count, exact for every scaled offset below 2**X_W
    localparam int     L_W   = $clog2(MOVE_STEPS);
    localparam int     X_W   = L_W + POS_W;
    localparam int     SH    = X_W + L_W;
    localparam longint RECIP = ((longint'(1) << SH) + longint'(MOVE_STEPS) - 1)
                               / longint'(MOVE_STEPS);
    localparam int     RCP_W = X_W + 2;
    localparam int     IM_W  = RCP_W + IDX_W;
    localparam int     PR_W  = IM_W + POS_W;
    localparam logic [RCP_W-1:0] RCP      = RCP_W'(RECIP);
    localparam logic [PR_W-1:0]  CEIL_ADD = PR_W'(longint'(MOVE_STEPS - 1) * RECIP);

    // configuration
    logic [TICK_W-1:0] debounce_reg;
    logic [TICK_W-1:0] step_ticks_reg;
    logic [POS_W-1:0]  on_pos_reg  [SERVOS];
    logic [POS_W-1:0]  off_pos_reg [SERVOS];

    // state
    logic              raw_prev_reg, raw_prev_next;
    logic              stable_reg, stable_next;
    logic [TICK_W-1:0] hold_reg, hold_next;
    logic              on_flag_reg, on_flag_next;
    logic              ramp_reg, ramp_next;
    logic [IDX_W-1:0]  step_idx_reg, step_idx_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [POS_W-1:0]  cur_reg [SERVOS];
    logic [POS_W-1:0]  cur_next [SERVOS];
    logic [IM_W-1:0]   im_reg, im_next;

    // output side
    out_item_t out_reg, skid_reg, item_new;
    logic      out_valid_reg, skid_valid_reg;

    logic              accept;
    logic              pop;
    logic              raw;
    logic              start_ramp;
    logic              advance;
    logic              finish;
    logic [TICK_W-1:0] spacing;
    logic [TICK_W:0]   tick_inc;

    logic [POS_W-1:0] tgt [SERVOS];
    logic             neg [SERVOS];
    logic [POS_W-1:0] mag [SERVOS];
    logic [PR_W-1:0]  prod [SERVOS];
    logic [POS_W-1:0] step_q [SERVOS];
    logic [POS_W-1:0] ramp_pos [SERVOS];
    logic [POS_W-1:0] pos [SERVOS];

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;
    assign raw      = s_tdata[0];
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(out_reg);

    // debounce and ramp sequencing
    always_comb
    begin
        raw_prev_next = raw_prev_reg;
        stable_next   = stable_reg;
        hold_next     = hold_reg;
        on_flag_next  = on_flag_reg;
        ramp_next     = ramp_reg;
        step_idx_next = step_idx_reg;
        tick_next     = tick_reg;
        start_ramp    = 1'b0;
        advance       = 1'b0;
        finish        = 1'b0;
        spacing       = (step_ticks_reg == '0) ? TICK_W'(1) : step_ticks_reg;
        tick_inc      = {1'b0, tick_reg} + (TICK_W + 1)'(1);
        if (!ramp_reg)
        begin
            if (raw != raw_prev_reg)
            begin
                raw_prev_next = raw;
                hold_next     = '0;
            end
            else if (hold_reg != TICK_MAX)
            begin
                hold_next = hold_reg + TICK_W'(1);
            end
            if (hold_next >= debounce_reg)
            begin
                stable_next = raw;
            end
            if (stable_next != on_flag_reg)
            begin
                start_ramp    = 1'b1;
                ramp_next     = 1'b1;
                step_idx_next = IDX_W'(1);
                tick_next     = '0;
            end
        end
        else
        begin
            if (hold_reg != TICK_MAX)
            begin
                hold_next = hold_reg + TICK_W'(1);
            end
            if (tick_inc >= {1'b0, spacing})
            begin
                tick_next = '0;
                if (step_idx_reg >= STEPS_I)
                begin
                    finish        = 1'b1;
                    on_flag_next  = !on_flag_reg;
                    ramp_next     = 1'b0;
                    step_idx_next = '0;
                end
                else
                begin
                    advance       = 1'b1;
                    step_idx_next = step_idx_reg + IDX_W'(1);
                end
            end
            else
            begin
                tick_next = tick_inc[TICK_W-1:0];
            end
        end
    end

    // per-servo ramp position
    always_comb
    begin
        // step index times the reciprocal
        im_next = im_reg;
        if (start_ramp)
        begin
            im_next = IM_W'(RCP);
        end
        else if (advance)
        begin
            im_next = im_reg + IM_W'(RCP);
        end
        else if (finish)
        begin
            im_next = '0;
        end
        for (int s = 0; s < SERVOS; s++)
        begin
            tgt[s]  = on_flag_reg ? off_pos_reg[s] : on_pos_reg[s];
            neg[s]  = tgt[s] < cur_reg[s];
            mag[s]  = neg[s] ? (cur_reg[s] - tgt[s]) : (tgt[s] - cur_reg[s]);
            // negative moves round toward minus infinity, so take the ceiling there
            prod[s]   = PR_W'(im_next) * PR_W'(mag[s]) + (neg[s] ? CEIL_ADD : '0);
            step_q[s] = prod[s][SH +: POS_W];
            ramp_pos[s] = neg[s] ? (cur_reg[s] - step_q[s]) : (cur_reg[s] + step_q[s]);
            cur_next[s] = finish ? tgt[s] : cur_reg[s];
            pos[s]      = ramp_next ? ramp_pos[s] : cur_next[s];
        end
        item_new.position_a    = pos[0];
        item_new.position_b    = pos[1];
        item_new.moving        = ramp_next;
        item_new.on_state      = on_flag_next;
        item_new.demand_stable = stable_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RESET;
            step_ticks_reg <= STEP_RESET;
            on_pos_reg[0]  <= ON_A_RESET;
            on_pos_reg[1]  <= ON_B_RESET;
            off_pos_reg[0] <= OFF_A_RESET;
            off_pos_reg[1] <= OFF_B_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEBOUNCE_TICKS: debounce_reg   <= cfg_data;
                CFG_STEP_TICKS:     step_ticks_reg <= cfg_data;
                CFG_ON_POSITION_A:  on_pos_reg[0]  <= cfg_data[POS_W-1:0];
                CFG_ON_POSITION_B:  on_pos_reg[1]  <= cfg_data[POS_W-1:0];
                CFG_OFF_POSITION_A: off_pos_reg[0] <= cfg_data[POS_W-1:0];
                CFG_OFF_POSITION_B: off_pos_reg[1] <= cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // tick state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_prev_reg <= 1'b0;
            stable_reg   <= 1'b0;
            hold_reg     <= '0;
            on_flag_reg  <= 1'b0;
            ramp_reg     <= 1'b0;
            step_idx_reg <= '0;
            tick_reg     <= '0;
            cur_reg[0]   <= OFF_A_RESET;
            cur_reg[1]   <= OFF_B_RESET;
            im_reg       <= '0;
        end
        else if (accept)
        begin
            raw_prev_reg <= raw_prev_next;
            stable_reg   <= stable_next;
            hold_reg     <= hold_next;
            on_flag_reg  <= on_flag_next;
            ramp_reg     <= ramp_next;
            step_idx_reg <= step_idx_next;
            tick_reg     <= tick_next;
            cur_reg[0]   <= cur_next[0];
            cur_reg[1]   <= cur_next[1];
            im_reg       <= im_next;
        end
    end

    // result register and skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg  <= skid_valid_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (!out_valid_reg || pop)
            begin
                out_reg <= item_new;
            end
            else
            begin
                skid_reg <= item_new;
            end
        end
        else if (pop && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    `DDSR_ASSERT_NEVER(a_skid_orphan, skid_valid_reg && !out_valid_reg, "orphan skid item")
    `DDSR_ASSERT_NEVER(a_step_rng, ramp_reg && (step_idx_reg - IDX_W'(1) >= STEPS_I), "bad step")
    `DDSR_ASSERT_NEVER(a_scaled_idx, im_reg != IM_W'(step_idx_reg) * RCP, "scaled index drift")
    `DDSR_ASSERT_NEVER(a_ramp_cause, ramp_reg && stable_reg == on_flag_reg, "ramp with no cause")
    `DDSR_ASSERT(a_toggle, !$stable(on_flag_reg) |-> ($past(ramp_reg) && !ramp_reg), "bad toggle")

endmodule

FILE: sim/debounced_dual_servo_ramp_tb.sv
// testbench for debounced_dual_servo_ramp: tick stream checked against a predictor
module debounced_dual_servo_ramp_tb;
    import ddsr_pkg::*;

    localparam int RAMP_STEPS = 250;
    localparam int IDLE_PCT   = 13;
    localparam int PHASE_TICKS = 200;
    localparam int HOLD_RUN   = 400;
    localparam int SHOW_MAX   = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    class servo_ramp_scoreboard;
        logic [TICK_W-1:0] settle_ticks = DEBOUNCE_RESET;
        logic [TICK_W-1:0] step_gap     = STEP_RESET;
        logic [POS_W-1:0]  on_a         = ON_A_RESET;
        logic [POS_W-1:0]  on_b         = ON_B_RESET;
        logic [POS_W-1:0]  off_a        = OFF_A_RESET;
        logic [POS_W-1:0]  off_b        = OFF_B_RESET;

        logic              last_raw   = 1'b0;
        logic              stable_now = 1'b0;
        logic [TICK_W-1:0] hold       = '0;
        logic              on_flag    = 1'b0;
        logic              in_ramp    = 1'b0;
        logic [9:0]        step       = '0;
        logic [TICK_W-1:0] tick_pos   = '0;
        logic [POS_W-1:0]  rest_a     = OFF_A_RESET;
        logic [POS_W-1:0]  rest_b     = OFF_B_RESET;

        out_item_t due_outputs[$];
        int errors     = 0;
        int ticks      = 0;
        int ramps_done = 0;

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_DEBOUNCE_TICKS: settle_ticks = value;
                CFG_STEP_TICKS:     step_gap     = value;
                CFG_ON_POSITION_A:  on_a         = value[POS_W-1:0];
                CFG_ON_POSITION_B:  on_b         = value[POS_W-1:0];
                CFG_OFF_POSITION_A: off_a        = value[POS_W-1:0];
                CFG_OFF_POSITION_B: off_b        = value[POS_W-1:0];
                default: ;
            endcase
        endfunction

        // start + floor(idx * (target - start) / steps)
        function logic [POS_W-1:0] ramp_point(logic [POS_W-1:0] start,
                                              logic [POS_W-1:0] target, logic [9:0] idx);
            int span;
            int num;
            int q;
            int pos;
            span = int'(target) - int'(start);
            num  = int'(idx) * span;
            if (num >= 0)
                q = num / RAMP_STEPS;
            else
                q = -((-num + RAMP_STEPS - 1) / RAMP_STEPS);
            pos = int'(start) + q;
            return pos[POS_W-1:0];
        endfunction

        function void accept_tick(logic level);
            logic [TICK_W-1:0] spacing;
            logic [POS_W-1:0]  tgt_a;
            logic [POS_W-1:0]  tgt_b;
            out_item_t         r;
            spacing = (step_gap == '0) ? 16'd1 : step_gap;
            tgt_a   = on_flag ? off_a : on_a;
            tgt_b   = on_flag ? off_b : on_b;
            ticks++;
            if (!in_ramp)
            begin
                if (level != last_raw)
                begin
                    last_raw = level;
                    hold     = '0;
                end
                else if (hold != TICK_MAX)
                begin
                    hold++;
                end
                if (hold >= settle_ticks)
                    stable_now = level;
                if (stable_now != on_flag)
                begin
                    in_ramp  = 1'b1;
                    step     = 10'd1;
                    tick_pos = '0;
                end
            end
            else
            begin
                if (hold != TICK_MAX)
                    hold++;
                if (int'(tick_pos) + 1 >= int'(spacing))
                begin
                    tick_pos = '0;
                    if (int'(step) >= RAMP_STEPS)
                    begin
                        rest_a  = tgt_a;
                        rest_b  = tgt_b;
                        on_flag = ~on_flag;
                        in_ramp = 1'b0;
                        step    = '0;
                        ramps_done++;
                    end
                    else
                    begin
                        step = step + 10'd1;
                    end
                end
                else
                begin
                    tick_pos++;
                end
            end
            r.position_a    = in_ramp ? ramp_point(rest_a, tgt_a, step) : rest_a;
            r.position_b    = in_ramp ? ramp_point(rest_b, tgt_b, step) : rest_b;
            r.moving        = in_ramp;
            r.on_state      = on_flag;
            r.demand_stable = stable_now;
            due_outputs.push_back(r);
        endfunction

        function void check_field(string label, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
            if (got !== want)
            begin
                errors++;
                if (errors <= SHOW_MAX)
                    $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
            end
        endfunction

        function void compare_result(logic [M_DATA_W-1:0] data);
            out_item_t got;
            out_item_t want;
            got = data[OUT_W-1:0];
            if (due_outputs.size() == 0)
            begin
                errors++;
                if (errors <= SHOW_MAX)
                    $display("%0t: result %h expected none, got one", $time, got);
                return;
            end
            want = due_outputs.pop_front();
            check_field("position_a", want.position_a, got.position_a);
            check_field("position_b", want.position_b, got.position_b);
            check_field("moving", POS_W'(want.moving), POS_W'(got.moving));
            check_field("on_state", POS_W'(want.on_state), POS_W'(got.on_state));
            check_field("demand_stable", POS_W'(want.demand_stable),
                        POS_W'(got.demand_stable));
        endfunction
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata   = '0;     // demand_raw
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;            // position_a, position_b, moving, on_state,
                                              // demand_stable
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    logic                 steady    = 1'b0;
    int                   phases    = 0;
    servo_ramp_scoreboard sb;

    debounced_dual_servo_ramp #(
        .MOVE_STEPS(RAMP_STEPS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.compare_result(m_tdata);
    end

    task automatic send_tick(input logic level);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - 1){1'b0}}, level};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.accept_tick(level);
    endtask

    task automatic await_drain();
        s_tvalid <= 1'b0;
        while (sb.due_outputs.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.set_register(idx, value);
    endtask

    task automatic apply_setting(input logic [CFG_W-1:0] settle, input logic [CFG_W-1:0] gap,
                                 input logic [POS_W-1:0] oa, input logic [POS_W-1:0] ob,
                                 input logic [POS_W-1:0] fa, input logic [POS_W-1:0] fb);
        await_drain();
        write_reg(CFG_DEBOUNCE_TICKS, settle);
        write_reg(CFG_STEP_TICKS, gap);
        write_reg(CFG_ON_POSITION_A, {8'($urandom), oa});
        write_reg(CFG_ON_POSITION_B, {8'($urandom), ob});
        write_reg(CFG_OFF_POSITION_A, {8'($urandom), fa});
        write_reg(CFG_OFF_POSITION_B, {8'($urandom), fb});
        // unused index, must leave everything alone
        write_reg($urandom_range(0, 1) ? CFG_SPARE_6 : CFG_SPARE_7, 16'($urandom));
        cfg_we <= 1'b0;
        phases++;
    endtask

    function automatic logic [POS_W-1:0] pick_angle();
        case ($urandom_range(0, 4))
            0: return 8'd0;
            1: return 8'd180;
            default: return 8'($urandom_range(0, 180));
        endcase
    endfunction

    // clean holds that outlast the debounce, mixed with short glitches
    task automatic random_traffic(input int count);
        int   sent;
        int   len;
        logic level;
        sent  = 0;
        level = sb.stable_now;
        while (sent < count)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                level = ~level;
                len   = int'(sb.settle_ticks) + $urandom_range(1, 6);
            end
            else
            begin
                level = 1'($urandom_range(0, 1));
                len   = $urandom_range(1, 3);
            end
            repeat (len)
            begin
                sent++;
                send_tick(level);
            end
        end
    endtask

    task automatic random_phase();
        apply_setting(($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 12)),
                      16'($urandom_range(0, 2)),
                      pick_angle(), pick_angle(), pick_angle(), pick_angle());
        random_traffic(PHASE_TICKS);
    endtask

    initial
    begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: short glitches never get through the debounce
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);

        // no debounce, zero spacing: ramp starts on the same tick
        apply_setting(16'd0, 16'd0, 8'd180, 8'd0, 8'd0, 8'd180);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);

        // widest settings mid ramp, targets swapped while moving
        apply_setting(16'hFFFF, 16'hFFFF, 8'd0, 8'd180, 8'd180, 8'd0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);

        repeat (3) random_phase();

        // long run with no idling: debounce, then a full ramp back to back
        apply_setting(16'd40, 16'd1, pick_angle(), pick_angle(), pick_angle(), pick_angle());
        steady = 1'b1;
        repeat (HOLD_RUN) send_tick(~sb.stable_now);
        steady = 1'b0;

        repeat (5) random_phase();

        await_drain();
        repeat (3) @(posedge clk);
        $display("covered %0d ticks over %0d register settings, %0d ramps completed",
                 sb.ticks, phases, sb.ramps_done);
        if (sb.errors == 0 && sb.due_outputs.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #(6000000);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/ddsr_pkg.sv
rtl/core/debounced_dual_servo_ramp.sv
sim/debounced_dual_servo_ramp_tb.sv
